@@ hw/rtl/btw_pkg.sv @@
package btw_pkg;

    localparam int POS_BITS    = 32;
    localparam int FRAC_BITS   = 16;
    localparam int DEN_BITS    = 16;
    localparam int DIV_STEPS   = POS_BITS + FRAC_BITS;
    localparam int WIDTH_BITS  = 13;
    localparam int TAP_BITS    = 12;
    localparam int CNT_BITS    = 3;
    localparam int WEIGHT_BITS = 18;
    localparam int MAX_WIDTH   = 4096;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_DENOMINATOR = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_WIDTH     = 1'd1;

    // One stage of the divider chain: partial remainder, and a word that
    // shifts dividend bits out at the top and quotient bits in at the bottom.
    typedef struct packed {
        logic                 valid;
        logic [DEN_BITS-1:0]  rem;
        logic [DIV_STEPS-1:0] word;
    } div_cell_t;

endpackage

@@ hw/rtl/btw_div_cell.sv @@
module btw_div_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [btw_pkg::DEN_BITS-1:0]  den,
    input  btw_pkg::div_cell_t            cell_in,
    output btw_pkg::div_cell_t            cell_out
);
    import btw_pkg::*;

    logic [DEN_BITS:0] trial;
    logic              qbit;
    logic [DEN_BITS:0] diff;
    logic              valid_reg;
    logic [DEN_BITS-1:0]  rem_reg, rem_next;
    logic [DIV_STEPS-1:0] word_reg, word_next;

    always_comb begin
        trial     = {cell_in.rem, cell_in.word[DIV_STEPS-1]};
        diff      = trial - {1'b0, den};
        qbit      = (trial >= {1'b0, den});
        rem_next  = qbit ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        word_next = {cell_in.word[DIV_STEPS-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= cell_in.valid;
        end
        if (en) begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
        end
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.rem   = rem_reg;
    assign cell_out.word  = word_reg;

endmodule

@@ hw/rtl/btw_weight.sv @@
module btw_weight (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [btw_pkg::DIV_STEPS-1:0]       quot,
    input  logic [btw_pkg::WIDTH_BITS-1:0]      width,
    output logic                                out_valid,
    output logic [btw_pkg::TAP_BITS-1:0]        first_tap,
    output logic [btw_pkg::CNT_BITS-1:0]        tap_count,
    output logic signed [btw_pkg::WEIGHT_BITS-1:0] weight_a,
    output logic signed [btw_pkg::WEIGHT_BITS-1:0] weight_b,
    output logic signed [btw_pkg::WEIGHT_BITS-1:0] weight_c,
    output logic signed [btw_pkg::WEIGHT_BITS-1:0] weight_d
);
    import btw_pkg::*;

    localparam int PROD_BITS = 2 * FRAC_BITS;
    localparam int ACC_BITS  = FRAC_BITS + 5;
    localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] TWO_ONE = ACC_BITS'(2) << FRAC_BITS;

    logic [POS_BITS-1:0]  idx_raw;
    logic [FRAC_BITS-1:0] t_raw;
    logic [TAP_BITS-1:0]  idx_sat;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [TAP_BITS-1:0]  idx1_reg, idx2_reg;
    logic [FRAC_BITS-1:0] t1_reg, t2t_reg, t2_reg;
    logic [PROD_BITS-1:0] p1_reg, p2_reg;
    logic [FRAC_BITS-1:0] t2_next, t3;
    logic [PROD_BITS-1:0] p1_next, p2_next, p2sum, p1sum;

    logic signed [ACC_BITS-1:0] ti, t2i, t3i, d0, d1, d2, d3;
    logic signed [ACC_BITS-1:0] h0, h1, h2, h3;
    logic [WIDTH_BITS:0] idx_p1, idx_p2;
    logic has_c, has_d;

    logic [TAP_BITS-1:0]  first_reg, first_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic signed [WEIGHT_BITS-1:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic signed [WEIGHT_BITS-1:0] wa_next, wb_next, wc_next, wd_next;

    // Stage 1: clamp the index to the last source sample and square t.
    always_comb begin
        idx_raw = quot[DIV_STEPS-1:FRAC_BITS];
        t_raw   = quot[FRAC_BITS-1:0];
        if (idx_raw > POS_BITS'(width - WIDTH_BITS'(1))) begin
            idx_sat = TAP_BITS'(width - WIDTH_BITS'(1));
        end else begin
            idx_sat = idx_raw[TAP_BITS-1:0];
        end
        p1_next = PROD_BITS'(t_raw) * PROD_BITS'(t_raw);
    end

    // Stage 2: round t^2 and multiply by t again.
    always_comb begin
        p1sum   = p1_reg + HALF;
        t2_next = p1sum[PROD_BITS-1:FRAC_BITS];
        p2_next = PROD_BITS'(t2_next) * PROD_BITS'(t1_reg);
    end

    // Stage 3: doubled weights, halving that rounds ties upward, edge trim.
    always_comb begin
        p2sum = p2_reg + HALF;
        t3    = p2sum[PROD_BITS-1:FRAC_BITS];
        ti    = $signed(ACC_BITS'(t2t_reg));
        t2i   = $signed(ACC_BITS'(t2_reg));
        t3i   = $signed(ACC_BITS'(t3));
        d0    = (t2i <<< 1) - ti - t3i;
        d1    = TWO_ONE - (t2i <<< 2) - t2i + (t3i <<< 1) + t3i;
        d2    = ti + (t2i <<< 2) - (t3i <<< 1) - t3i;
        d3    = t3i - t2i;
        h0    = (d0 + ACC_BITS'(1)) >>> 1;
        h1    = (d1 + ACC_BITS'(1)) >>> 1;
        h2    = (d2 + ACC_BITS'(1)) >>> 1;
        h3    = (d3 + ACC_BITS'(1)) >>> 1;

        // The taps one and two past the index exist while they stay inside the width.
        idx_p1 = (WIDTH_BITS + 1)'(idx2_reg) + (WIDTH_BITS + 1)'(1);
        idx_p2 = (WIDTH_BITS + 1)'(idx2_reg) + (WIDTH_BITS + 1)'(2);
        has_c  = idx_p1 < (WIDTH_BITS + 1)'(width);
        has_d  = idx_p2 < (WIDTH_BITS + 1)'(width);

        if (idx2_reg == '0) begin
            first_next = '0;
            count_next = CNT_BITS'(1) + CNT_BITS'(has_c) + CNT_BITS'(has_d);
            wa_next    = WEIGHT_BITS'(h1);
            wb_next    = has_c ? WEIGHT_BITS'(h2) : '0;
            wc_next    = has_d ? WEIGHT_BITS'(h3) : '0;
            wd_next    = '0;
        end else begin
            first_next = idx2_reg - TAP_BITS'(1);
            count_next = CNT_BITS'(2) + CNT_BITS'(has_c) + CNT_BITS'(has_d);
            wa_next    = WEIGHT_BITS'(h0);
            wb_next    = WEIGHT_BITS'(h1);
            wc_next    = has_c ? WEIGHT_BITS'(h2) : '0;
            wd_next    = has_d ? WEIGHT_BITS'(h3) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            idx1_reg  <= idx_sat;
            t1_reg    <= t_raw;
            p1_reg    <= p1_next;
            idx2_reg  <= idx1_reg;
            t2t_reg   <= t1_reg;
            t2_reg    <= t2_next;
            p2_reg    <= p2_next;
            first_reg <= first_next;
            count_reg <= count_next;
            wa_reg    <= wa_next;
            wb_reg    <= wb_next;
            wc_reg    <= wc_next;
            wd_reg    <= wd_next;
        end
    end

    assign out_valid = v3_reg;
    assign first_tap = first_reg;
    assign tap_count = count_reg;
    assign weight_a  = wa_reg;
    assign weight_b  = wb_reg;
    assign weight_c  = wc_reg;
    assign weight_d  = wd_reg;

endmodule

@@ hw/rtl/bicubic_tap_weights.sv @@
// Channel  Ports                                       Direction
// s_       s_valid, s_ready, s_position_num            in
// m_       m_valid, m_ready, m_first_tap, m_tap_count,
//          m_weight_a .. m_weight_d                    out
// cfg      cfg_we, cfg_index, cfg_data                 in, write only
//
// One position is taken every cycle unless the pipeline holds (see below).
// A position passes through the 48-cell restoring divider chain (32 index bits
// and 16 fraction bits, one per cell) and then three registered weight stages.
// Reset is synchronous and active low; it empties the pipeline and loads
// a denominator of 1 and a width of 4096.
// When the output register is full and not taken, the whole pipeline holds.
module bicubic_tap_weights (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [btw_pkg::POS_BITS-1:0]            s_position_num,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [btw_pkg::TAP_BITS-1:0]            m_first_tap,
    output logic [btw_pkg::CNT_BITS-1:0]            m_tap_count,
    output logic signed [btw_pkg::WEIGHT_BITS-1:0]  m_weight_a,
    output logic signed [btw_pkg::WEIGHT_BITS-1:0]  m_weight_b,
    output logic signed [btw_pkg::WEIGHT_BITS-1:0]  m_weight_c,
    output logic signed [btw_pkg::WEIGHT_BITS-1:0]  m_weight_d,
    input  logic                                    cfg_we,
    input  logic [btw_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [btw_pkg::DEN_BITS-1:0]            cfg_data
);
    import btw_pkg::*;

    logic [DEN_BITS-1:0]   den_reg;
    logic [WIDTH_BITS-1:0] width_reg;
    logic [DEN_BITS-1:0]   den_eff;
    logic [WIDTH_BITS-1:0] width_eff;
    logic                  advance;
    div_cell_t             chain [DIV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            den_reg   <= DEN_BITS'(1);
            width_reg <= WIDTH_BITS'(MAX_WIDTH);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STEP_DENOMINATOR: den_reg   <= cfg_data;
                REG_SOURCE_WIDTH:     width_reg <= cfg_data[WIDTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        den_eff = (den_reg == '0) ? DEN_BITS'(1) : den_reg;
        if (width_reg == '0) begin
            width_eff = WIDTH_BITS'(1);
        end else if (width_reg > WIDTH_BITS'(MAX_WIDTH)) begin
            width_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            width_eff = width_reg;
        end
    end

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    assign chain[0].valid = s_valid && advance;
    assign chain[0].rem   = '0;
    assign chain[0].word  = {s_position_num, FRAC_BITS'(0)};

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        btw_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (advance),
            .den      (den_eff),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    btw_weight u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (chain[DIV_STEPS].valid),
        .quot      (chain[DIV_STEPS].word),
        .width     (width_eff),
        .out_valid (m_valid),
        .first_tap (m_first_tap),
        .tap_count (m_tap_count),
        .weight_a  (m_weight_a),
        .weight_b  (m_weight_b),
        .weight_c  (m_weight_c),
        .weight_d  (m_weight_d)
    );

endmodule

@@ dv/tb_bicubic_tap_weights.sv @@
module tb_bicubic_tap_weights;
    timeunit 1ns;
    timeprecision 1ps;

    import btw_pkg::*;

    typedef struct {
        logic [TAP_BITS-1:0]           first_tap;
        logic [CNT_BITS-1:0]           tap_count;
        logic signed [WEIGHT_BITS-1:0] wt [4];
    } tap_set_t;

    class tap_scoreboard;
        tap_set_t            expected_q [$];
        logic [DEN_BITS-1:0] denominator = 1;
        logic [WIDTH_BITS-1:0] src_width = 4096;
        int mismatches = 0;
        int checked = 0;

        function longint effective_den();
            return (denominator == 0) ? 1 : longint'(denominator);
        endfunction

        function longint effective_width();
            longint w;
            w = longint'(src_width);
            if (w < 1) w = 1;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            return w;
        endfunction

        // Halves a doubled weight, ties rounding toward plus infinity.
        function longint halve(longint v);
            return (v >= 0) ? ((v + 1) >>> 1) : -((-v) >>> 1);
        endfunction

        function void note_position(logic [POS_BITS-1:0] num);
            longint den, w, idx, rem, t, t2, t3, one, first;
            longint wts [4];
            tap_set_t e;
            int n;
            den = effective_den();
            w = effective_width();
            idx = longint'(num) / den;
            rem = longint'(num) % den;
            if (idx > w - 1) idx = w - 1;
            t  = (rem << FRAC_BITS) / den;
            t2 = (t * t + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            t3 = (t2 * t + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            one = 64'd1 << FRAC_BITS;
            wts[0] = halve(2 * t2 - t - t3);
            wts[1] = halve(2 * one - 5 * t2 + 3 * t3);
            wts[2] = halve(t + 4 * t2 - 3 * t3);
            wts[3] = halve(t3 - t2);
            for (int k = 0; k < 4; k++) e.wt[k] = '0;
            n = 0;
            if (idx == 0) begin
                first = 0;
                e.wt[n] = wts[1][WEIGHT_BITS-1:0];
                n = n + 1;
                if (0 < w - 1) begin
                    e.wt[n] = wts[2][WEIGHT_BITS-1:0];
                    n = n + 1;
                end
                if (0 < w - 2) begin
                    e.wt[n] = wts[3][WEIGHT_BITS-1:0];
                    n = n + 1;
                end
            end else begin
                first = idx - 1;
                e.wt[0] = wts[0][WEIGHT_BITS-1:0];
                e.wt[1] = wts[1][WEIGHT_BITS-1:0];
                n = 2;
                if (first < w - 2) begin
                    e.wt[n] = wts[2][WEIGHT_BITS-1:0];
                    n = n + 1;
                end
                if (first < w - 3) begin
                    e.wt[n] = wts[3][WEIGHT_BITS-1:0];
                    n = n + 1;
                end
            end
            e.first_tap = first[TAP_BITS-1:0];
            e.tap_count = n[CNT_BITS-1:0];
            expected_q.push_back(e);
        endfunction

        function void check_result(tap_set_t got);
            tap_set_t e;
            bit bad;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected, first_tap %0d",
                             got.first_tap);
                return;
            end
            e = expected_q.pop_front();
            bad = (e.first_tap !== got.first_tap) || (e.tap_count !== got.tap_count);
            for (int k = 0; k < 4; k++)
                if (e.wt[k] !== got.wt[k]) bad = 1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: exp tap %0d cnt %0d w %0d %0d %0d %0d,",
                              " got tap %0d cnt %0d w %0d %0d %0d %0d"},
                             e.first_tap, e.tap_count, e.wt[0], e.wt[1], e.wt[2], e.wt[3],
                             got.first_tap, got.tap_count, got.wt[0], got.wt[1],
                             got.wt[2], got.wt[3]);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [POS_BITS-1:0] s_position_num = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [TAP_BITS-1:0] m_first_tap;
    logic [CNT_BITS-1:0] m_tap_count;
    logic signed [WEIGHT_BITS-1:0] m_weight_a, m_weight_b, m_weight_c, m_weight_d;
    logic cfg_we = 0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [DEN_BITS-1:0] cfg_data = '0;

    tap_scoreboard sb = new();
    bit calm = 0;
    bit hold_request = 0;
    int positions_sent = 0;
    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    bicubic_tap_weights dut (.*);

    always @(posedge aclk) begin
        tap_set_t got;
        if (s_valid && s_ready) sb.note_position(s_position_num);
        if (m_valid && m_ready) begin
            got.first_tap = m_first_tap;
            got.tap_count = m_tap_count;
            got.wt[0] = m_weight_a;
            got.wt[1] = m_weight_b;
            got.wt[2] = m_weight_c;
            got.wt[3] = m_weight_d;
            sb.check_result(got);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("ERROR: no transfer for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random back-pressure plus one long hold on request.
    initial begin
        int stall;
        stall = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 0;
                repeat (300) @(posedge aclk);
                hold_request = 0;
                m_ready <= 1;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 0;
            end else begin
                stall = pick_gap();
                m_ready <= (stall == 0);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [DEN_BITS-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == REG_STEP_DENOMINATOR) sb.denominator = val;
        else sb.src_width = val[WIDTH_BITS-1:0];
    endtask

    task automatic send_position(logic [POS_BITS-1:0] num);
        int gap;
        s_valid <= 1;
        s_position_num <= num;
        do @(posedge aclk); while (!s_ready);
        positions_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Mostly well-formed positions around the valid index range.
    function logic [POS_BITS-1:0] random_position();
        longint den, w, idx, rem;
        int r;
        den = sb.effective_den();
        w = sb.effective_width();
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom;
        idx = (r < 4) ? $urandom_range(0, 3) :
              (r < 6) ? w - 1 - $urandom_range(0, 3) : $urandom_range(0, w + 2);
        if (idx < 0) idx = 0;
        rem = $urandom_range(0, den - 1);
        if (r == 9) rem = ($urandom_range(0, 1) == 1) ? den - 1 : 0;
        return POS_BITS'(idx * den + rem);
    endfunction

    initial begin
        logic [DEN_BITS-1:0] den_list [10] = '{1, 0, 65535, 3, 7, 256, 1000, 100, 65535, 0};
        logic [DEN_BITS-1:0] wid_list [10] = '{4096, 1, 8191, 2, 3, 5, 4096, 0, 1, 4097};
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Default setting: both position extremes, the left edge and past the right edge.
        foreach (den_list[i]) begin
            if (i > 0) begin
                write_reg(REG_STEP_DENOMINATOR, den_list[i]);
                write_reg(REG_SOURCE_WIDTH, wid_list[i]);
            end
            calm = (i % 3 == 2);
            if (i == 0) begin
                send_position(0);
                send_position(1);
                send_position(2);
                send_position(4094);
                send_position(4095);
                send_position(4096);
                send_position(32'hFFFF_FFFF);
                send_position(32'h8000_0000);
            end else if (i == 3) begin
                for (int p = 0; p < 8; p++) send_position(p);
            end
            if (i == 6) hold_request = 1;
            repeat (82) send_position(random_position());
            drain();
        end

        $display("Sent %0d positions over %0d register settings; %0d weight sets checked.",
                 positions_sent, $size(den_list), sb.checked);
        $display("Covered zero and maximal denominators, widths 0 to 8191, a long stall.");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
